>>> rtl/png_unf_pkg.sv
package png_unf_pkg;

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filt_t;

	typedef enum logic [1:0] {
		REG_PIXELS_PER_ROW = 2'd0,
		REG_ROW_COUNT      = 2'd1,
		REG_WITH_ALPHA     = 2'd2
	} reg_idx_t;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int PPR_W = 13;
	localparam int ROWS_W = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam logic [7:0] FILT_MAX = 8'd4;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	typedef struct packed {
		logic       is_err;
		logic [7:0] data_byte;
		filt_t      filter;
		logic [1:0] chan;
		logic       first_row;
		logic       last_col;
		logic       add_alpha;
		logic       fin;
	} op_t;

	typedef struct packed {
		logic full;
		logic valid;
	} q_stat_t;

	typedef struct packed {
		logic alpha_pend;
		logic out_load;
	} back_stat_t;

	function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic signed [9:0] da;
		logic signed [9:0] db;
		logic signed [9:0] dc;
		logic [9:0] pa;
		logic [9:0] pb;
		logic [9:0] pc;
		da = $signed({2'b00, b}) - $signed({2'b00, c});
		db = $signed({2'b00, a}) - $signed({2'b00, c});
		dc = da + db;
		pa = (da < 0) ? 10'(-da) : 10'(da);
		pb = (db < 0) ? 10'(-db) : 10'(db);
		pc = (dc < 0) ? 10'(-dc) : 10'(dc);
		if (pa <= pb && pa <= pc) begin
			return a;
		end
		if (pb <= pc) begin
			return b;
		end
		return c;
	endfunction

endpackage

>>> rtl/png_scanline_unfilter.sv
// A sample beat passes the queue, stage-one and output registers. Throughput: one
// input beat per cycle in RGBA mode while the queue has room; in RGB mode every third
// channel also emits an alpha beat, which stalls the input. Filter type beats produce
// no output unless they are errors. The previous-row store is one RAM port pair. Reset
// (arst_n low) resets all counters, windows, state flags and the output valid flag;
// the previous-row store is not cleared and reads as undefined until written.
module png_scanline_unfilter #(
	parameter int MAX_WIDTH = 4096,
	parameter int MAX_HEIGHT_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [png_unf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [png_unf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [7:0]                         s_axis_tdata,  // [7:0] data_byte
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [7:0]                         m_axis_tdata,  // [7:0] pixel_byte
	output logic                               m_axis_tlast,
	output logic                               m_axis_tuser   // [0] bad_stream
);

	localparam int CW = $clog2(MAX_WIDTH * 4);
	localparam int OPW = $bits(png_unf_pkg::op_t);
	localparam int QW = CW + OPW;

	png_unf_pkg::q_stat_t    q_stat;
	png_unf_pkg::back_stat_t back_stat;
	png_unf_pkg::op_t        push_op;
	png_unf_pkg::op_t        head_op;
	logic [CW-1:0]           push_col;
	logic [CW-1:0]           head_col;
	logic [QW-1:0]           head_data;
	logic                    q_push;
	logic                    q_pop;

	png_unf_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT_BITS(MAX_HEIGHT_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_valid(s_axis_tvalid),
		.s_ready(s_axis_tready),
		.s_data(s_axis_tdata),
		.q_stat(q_stat),
		.push(q_push),
		.push_op(push_op),
		.push_col(push_col)
	);

	png_unf_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data({push_col, push_op}),
		.pop(q_pop),
		.head_data(head_data),
		.stat(q_stat)
	);

	assign head_col = head_data[QW-1:OPW];
	assign head_op = png_unf_pkg::op_t'(head_data[OPW-1:0]);

	png_unf_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_stat(q_stat),
		.head_op(head_op),
		.head_col(head_col),
		.pop(q_pop),
		.m_valid(m_axis_tvalid),
		.m_ready(m_axis_tready),
		.m_data(m_axis_tdata),
		.m_last(m_axis_tlast),
		.m_user(m_axis_tuser),
		.stat(back_stat)
	);

`ifndef NO_ASSERTIONS
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("Front pushed an operation into a full queue.");

	a_alpha_follows: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.alpha_pend && back_stat.out_load |=>
		m_axis_tvalid && m_axis_tdata == png_unf_pkg::ALPHA_OPAQUE && !m_axis_tuser)
		else $error("Pending alpha was not emitted as an opaque beat.");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tuser |=> !m_axis_tvalid || m_axis_tuser)
		else $error("A good beat followed an error beat.");
`endif

endmodule

>>> rtl/png_unf_ram.sv
module png_unf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/png_unf_front.sv
module png_unf_front #(
	parameter int MAX_WIDTH = 4096,
	parameter int MAX_HEIGHT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [png_unf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [png_unf_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                                s_valid,
	output logic                                s_ready,
	input  logic [7:0]                          s_data,
	input  png_unf_pkg::q_stat_t                q_stat,
	output logic                                push,
	output png_unf_pkg::op_t                    push_op,
	output logic [$clog2(MAX_WIDTH*4)-1:0]      push_col
);

	localparam int CW = $clog2(MAX_WIDTH * 4);
	localparam int XW = (CW + 1 > png_unf_pkg::PPR_W) ? CW + 1 : png_unf_pkg::PPR_W;
	localparam int HB = MAX_HEIGHT_BITS;
	localparam int RW = (HB > png_unf_pkg::ROWS_W) ? HB : png_unf_pkg::ROWS_W;
	localparam logic [XW-1:0] MAXW_X = XW'(MAX_WIDTH);
	localparam logic [RW-1:0] LIM_X = RW'((64'd1 << HB) - 64'd1);

	logic [png_unf_pkg::PPR_W-1:0]  ppr_q;
	logic [png_unf_pkg::ROWS_W-1:0] rows_q;
	logic                           alpha_q;

	logic [CW-1:0]              col_q;
	logic [1:0]                 chan_q;
	logic [HB-1:0]              row_q;
	png_unf_pkg::filt_t         filter_q;
	logic                       await_q;
	logic                       err_q;
	logic                       done_q;

	logic [XW-1:0] ppr_x;
	logic [XW-1:0] w_x;
	logic [XW-1:0] stride_x;
	logic [XW-1:0] col_x;
	logic [XW-1:0] col_eff_x;
	logic [CW-1:0] col_eff;
	logic [RW-1:0] rc_x;
	logic [RW-1:0] rows_x;
	logic [RW-1:0] row_x;
	logic [RW:0]   row_next_x;
	logic          past_end;
	logic          last_row;
	logic          last_col;
	logic [1:0]    ch_last;
	logic [1:0]    chan_eff;
	logic          last_chan;
	logic          is_err;
	logic          take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q <= png_unf_pkg::PPR_W'(1);
			rows_q <= png_unf_pkg::ROWS_W'(1);
			alpha_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				png_unf_pkg::REG_PIXELS_PER_ROW: ppr_q <= cfg_data[png_unf_pkg::PPR_W-1:0];
				png_unf_pkg::REG_ROW_COUNT: rows_q <= cfg_data[png_unf_pkg::ROWS_W-1:0];
				png_unf_pkg::REG_WITH_ALPHA: alpha_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ppr_x = XW'(ppr_q);
		if (ppr_x == '0) begin
			w_x = XW'(1);
		end else if (ppr_x > MAXW_X) begin
			w_x = MAXW_X;
		end else begin
			w_x = ppr_x;
		end
		stride_x = alpha_q ? (w_x << 2) : ((w_x << 1) + w_x);

		rc_x = RW'(rows_q);
		rows_x = (rc_x > LIM_X) ? LIM_X : rc_x;
		if (rows_x == '0) begin
			rows_x = RW'(1);
		end
		row_x = RW'(row_q);
		past_end = row_x >= rows_x;
		row_next_x = {1'b0, row_x} + (RW + 1)'(1);
		last_row = row_next_x >= {1'b0, rows_x};

		col_x = XW'(col_q);
		col_eff_x = (col_x >= stride_x) ? stride_x - XW'(1) : col_x;
		col_eff = col_eff_x[CW-1:0];
		last_col = col_eff_x == stride_x - XW'(1);

		ch_last = alpha_q ? 2'd3 : 2'd2;
		chan_eff = (chan_q > ch_last) ? ch_last : chan_q;
		last_chan = chan_eff == ch_last;

		is_err = err_q || done_q || past_end || (await_q && s_data > png_unf_pkg::FILT_MAX);
	end

	assign s_ready = !q_stat.full;
	assign take = s_valid && s_ready;
	assign push = take && (is_err || !await_q);

	always_comb begin
		push_op.is_err = is_err;
		push_op.data_byte = s_data;
		push_op.filter = filter_q;
		push_op.chan = chan_eff;
		push_op.first_row = row_q == '0;
		push_op.last_col = last_col;
		push_op.add_alpha = !alpha_q && last_chan;
		push_op.fin = last_col && last_row;
	end
	assign push_col = col_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			chan_q <= '0;
			row_q <= '0;
			filter_q <= png_unf_pkg::FILT_NONE;
			await_q <= 1'b1;
			err_q <= 1'b0;
			done_q <= 1'b0;
		end else if (take) begin
			if (is_err) begin
				err_q <= 1'b1;
			end else if (await_q) begin
				filter_q <= png_unf_pkg::filt_t'(s_data[2:0]);
				await_q <= 1'b0;
			end else if (last_col) begin
				col_q <= '0;
				chan_q <= '0;
				await_q <= 1'b1;
				if (last_row) begin
					done_q <= 1'b1;
				end
				row_q <= row_q + HB'(1);
			end else begin
				col_q <= col_eff + CW'(1);
				chan_q <= last_chan ? 2'd0 : chan_eff + 2'd1;
			end
		end
	end

endmodule

>>> rtl/png_unf_queue.sv
module png_unf_queue #(
	parameter int WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [WIDTH-1:0]     push_data,
	input  logic                 pop,
	output logic [WIDTH-1:0]     head_data,
	output png_unf_pkg::q_stat_t stat
);

	localparam int DEPTH = png_unf_pkg::QUEUE_DEPTH;
	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [NW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full = count_q == NW'(DEPTH);
	assign stat.valid = count_q != '0;
	assign do_push = push && !stat.full;
	assign do_pop = pop && stat.valid;
	assign head_data = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + NW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

>>> rtl/png_unf_back.sv
module png_unf_back #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  png_unf_pkg::q_stat_t             q_stat,
	input  png_unf_pkg::op_t                 head_op,
	input  logic [$clog2(MAX_WIDTH*4)-1:0]   head_col,
	output logic                             pop,
	output logic                             m_valid,
	input  logic                             m_ready,
	output logic [7:0]                       m_data,
	output logic                             m_last,
	output logic                             m_user,
	output png_unf_pkg::back_stat_t          stat
);

	localparam int DEPTH = MAX_WIDTH * 4;
	localparam int CW = $clog2(DEPTH);

	png_unf_pkg::op_t op_s1;
	logic [CW-1:0]    col_s1;
	logic             valid_s1_q;
	logic             alpha_pend_q;
	logic             alpha_fin_q;
	logic             m_valid_q;
	logic [7:0]       m_data_q;
	logic             m_last_q;
	logic             m_user_q;
	logic [7:0]       left_q [4];
	logic [7:0]       ul_q [4];

	logic       out_load;
	logic       adv_s1;
	logic       store_we;
	logic [7:0] up_raw;
	logic [7:0] up;
	logic [7:0] left;
	logic [7:0] ul;
	logic [8:0] avg_sum;
	logic [7:0] pred;
	logic [7:0] value;

	assign out_load = !m_valid_q || m_ready;
	assign adv_s1 = valid_s1_q && !alpha_pend_q && out_load;
	assign pop = q_stat.valid && (!valid_s1_q || adv_s1);
	assign store_we = adv_s1 && !op_s1.is_err;

	png_unf_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk(clk),
		.we(store_we),
		.waddr(col_s1),
		.wdata(value),
		.re(pop),
		.raddr(head_col),
		.rdata(up_raw)
	);

	always_comb begin
		up = op_s1.first_row ? 8'd0 : up_raw;
		left = left_q[op_s1.chan];
		ul = ul_q[op_s1.chan];
		avg_sum = {1'b0, left} + {1'b0, up};
		unique case (op_s1.filter)
			png_unf_pkg::FILT_SUB: pred = left;
			png_unf_pkg::FILT_UP: pred = up;
			png_unf_pkg::FILT_AVG: pred = avg_sum[8:1];
			png_unf_pkg::FILT_PAETH: pred = png_unf_pkg::paeth_pick(left, up, ul);
			default: pred = 8'd0;
		endcase
		value = op_s1.data_byte + pred;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1 <= head_op;
			col_s1 <= head_col;
		end
		if (out_load && alpha_pend_q) begin
			m_data_q <= png_unf_pkg::ALPHA_OPAQUE;
			m_last_q <= alpha_fin_q;
			m_user_q <= 1'b0;
		end else if (adv_s1) begin
			if (op_s1.is_err) begin
				m_data_q <= 8'd0;
				m_last_q <= 1'b0;
				m_user_q <= 1'b1;
			end else begin
				m_data_q <= value;
				m_last_q <= op_s1.fin && !op_s1.add_alpha;
				m_user_q <= 1'b0;
			end
		end
		if (adv_s1) begin
			alpha_fin_q <= op_s1.fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
			alpha_pend_q <= 1'b0;
			m_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				left_q[i] <= 8'd0;
				ul_q[i] <= 8'd0;
			end
		end else begin
			if (pop) begin
				valid_s1_q <= 1'b1;
			end else if (adv_s1) begin
				valid_s1_q <= 1'b0;
			end
			if (out_load) begin
				m_valid_q <= alpha_pend_q || valid_s1_q;
			end
			if (out_load && alpha_pend_q) begin
				alpha_pend_q <= 1'b0;
			end else if (store_we && op_s1.add_alpha) begin
				alpha_pend_q <= 1'b1;
			end
			if (store_we) begin
				if (op_s1.last_col) begin
					for (int i = 0; i < 4; i++) begin
						left_q[i] <= 8'd0;
						ul_q[i] <= 8'd0;
					end
				end else begin
					left_q[op_s1.chan] <= value;
					ul_q[op_s1.chan] <= up;
				end
			end
		end
	end

	assign m_valid = m_valid_q;
	assign m_data = m_data_q;
	assign m_last = m_last_q;
	assign m_user = m_user_q;
	assign stat.alpha_pend = alpha_pend_q;
	assign stat.out_load = out_load;

endmodule
